[rtl/core/rmap_pkg.sv]
`default_nettype none
package rmap_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int FRAC_BITS  = 8;
    localparam int FOCAL_W    = 20;
    localparam int DIM_W      = 8;
    localparam int G_W        = 2 * FOCAL_W;
    localparam int MAG_W      = 8;
    localparam int NUM_W      = MAG_W + G_W + FRAC_BITS - 1;
    localparam int QBITS      = 18;
    localparam int REM_W      = NUM_W + 3;
    localparam int LIMIT      = (MAX_WIDTH + MAX_HEIGHT) << FRAC_BITS;
    localparam int BANK_AW    = 12;
    localparam int BANK_DEPTH = 1 << BANK_AW;

    localparam logic [DIM_W-1:0]   WIDTH_RESET  = 8'd128;
    localparam logic [DIM_W-1:0]   HEIGHT_RESET = 8'd128;
    localparam logic [FOCAL_W-1:0] FOCAL_RESET  = 20'd32768;
    localparam logic [FOCAL_W-1:0] FOCAL_MIN    = 20'd256;
    localparam logic [DIM_W-1:0]   DIM_MIN      = 8'd2;
    localparam logic [DIM_W-1:0]   WIDTH_MAX    = 8'd128;
    localparam logic [DIM_W-1:0]   HEIGHT_MAX   = 8'd128;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FOCAL  = 2'd2;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [6:0] pixel_row;
        logic [6:0] pixel_col;
        logic [7:0] load_red;
        logic [7:0] load_green;
        logic [7:0] load_blue;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       source_inside;
    } rsp_t;

    typedef struct packed {
        logic              is_query;
        logic              in_image;
        logic [6:0]        row;
        logic [6:0]        col;
        logic signed [8:0] hx;
        logic signed [8:0] hy;
        logic [23:0]       rgb;
    } item_t;

endpackage
`default_nettype wire

[rtl/core/rmap_front.sv]
`default_nettype none
module rmap_front (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       req_valid,
    output logic                            req_ready,
    input  wire rmap_pkg::req_t             req_data,
    input  wire logic [rmap_pkg::DIM_W-1:0] width,
    input  wire logic [rmap_pkg::DIM_W-1:0] height,
    output logic                            push_valid,
    input  wire logic                       push_ready,
    output rmap_pkg::item_t                 push_item
);

    logic            f_valid_reg;
    rmap_pkg::item_t f_item_reg;
    rmap_pkg::item_t f_item_next;

    always_comb
    begin
        f_item_next.is_query = (req_data.req_type == rmap_pkg::REQ_QUERY);
        f_item_next.in_image = ({1'b0, req_data.pixel_row} < height) &&
                               ({1'b0, req_data.pixel_col} < width);
        f_item_next.row = req_data.pixel_row;
        f_item_next.col = req_data.pixel_col;
        f_item_next.hx  = $signed({1'b0, req_data.pixel_col, 1'b0}) - $signed({1'b0, width});
        f_item_next.hy  = $signed({1'b0, req_data.pixel_row, 1'b0}) - $signed({1'b0, height});
        f_item_next.rgb = {req_data.load_red, req_data.load_green, req_data.load_blue};
    end

    assign req_ready  = !f_valid_reg || push_ready;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            f_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            f_item_reg <= f_item_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/rmap_queue.sv]
`default_nettype none
module rmap_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire rmap_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output rmap_pkg::item_t      pop_item
);

    localparam int AW = $clog2(DEPTH);

    rmap_pkg::item_t entry_reg [0:DEPTH-1];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic [AW:0]     count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != (AW+1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

[rtl/core/rmap_div.sv]
`default_nettype none
module rmap_div (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic [rmap_pkg::NUM_W-1:0] num,
    input  wire logic [rmap_pkg::G_W-1:0]   den,
    output logic [rmap_pkg::QBITS-1:0]      quot,
    output logic                            ovf,
    output logic                            rem_nz
);

    localparam int QB = rmap_pkg::QBITS;
    localparam int RW = rmap_pkg::REM_W;

    logic [rmap_pkg::NUM_W-1:0] rem_reg [0:QB];
    logic [rmap_pkg::G_W-1:0]   den_reg [0:QB];
    logic [QB-1:0]              q_reg   [0:QB];
    logic                       ovf_reg [0:QB];

    // quotient at or above 2^QBITS is flagged, never resolved
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= (RW'(num) >= {den, {QB{1'b0}}});
        end
    end

    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [RW-1:0] dsh;
        logic [RW-1:0] rext;
        logic          take;
        logic [rmap_pkg::NUM_W-1:0] rem_next;
        logic [QB-1:0] q_next;

        always_comb
        begin
            dsh      = RW'(den_reg[k-1]) << (QB - k);
            rext     = RW'(rem_reg[k-1]);
            take     = (rext >= dsh);
            rem_next = take ? rmap_pkg::NUM_W'(rext - dsh) : rem_reg[k-1];
            q_next   = q_reg[k-1] | (QB'(take) << (QB - k));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quot   = q_reg[QB];
    assign ovf    = ovf_reg[QB];
    assign rem_nz = (rem_reg[QB] != '0);

endmodule
`default_nettype wire

[rtl/core/rmap_back.sv]
`default_nettype none
module rmap_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire rmap_pkg::item_t              pop_item,
    input  wire logic [rmap_pkg::DIM_W-1:0]   width,
    input  wire logic [rmap_pkg::DIM_W-1:0]   height,
    input  wire logic [rmap_pkg::FOCAL_W-1:0] focal,
    output logic                              rsp_valid,
    input  wire logic                         rsp_ready,
    output rmap_pkg::rsp_t                    rsp_data
);

    localparam int QB  = rmap_pkg::QBITS;
    localparam int GW  = rmap_pkg::G_W;
    localparam int NW  = rmap_pkg::NUM_W;
    localparam int FB  = rmap_pkg::FRAC_BITS;
    localparam int AW  = rmap_pkg::BANK_AW;

    typedef struct packed {
        logic        is_query;
        logic        ok;
        logic        neg_x;
        logic        neg_y;
        logic [6:0]  row;
        logic [6:0]  col;
        logic [23:0] rgb;
    } side_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] idx;
        logic [7:0] frac;
    } axis_t;

    function automatic axis_t map_axis(input logic [QB-1:0] q, input logic ovf,
                                       input logic rnz, input logic neg,
                                       input logic [7:0] size);
        logic [QB:0]   qc;
        logic [19:0]   center;
        logic [19:0]   pos;
        logic [11:0]   ip;
        logic          bad;
        axis_t         res;
        center = {5'b0, size, 7'b0};
        qc     = neg ? ({1'b0, q} + {{QB{1'b0}}, rnz}) : {1'b0, q};
        bad    = ovf || (qc > (QB+1)'(rmap_pkg::LIMIT)) ||
                 (neg && ({1'b0, qc} > center));
        pos    = neg ? (center - {1'b0, qc}) : (center + {1'b0, qc});
        ip     = pos[19:8];
        bad    = bad || ((ip + 12'd1) >= {4'b0, size});
        res.ok   = !bad;
        res.idx  = ip[6:0];
        res.frac = pos[7:0];
        return res;
    endfunction

    logic adv;

    // stage 1: squares and focal power
    logic        s1_valid_reg;
    side_t       s1_side_reg;
    logic [16:0] s1_hx2_reg, s1_hy2_reg;
    logic [7:0]  s1_magx_reg, s1_magy_reg;
    logic [GW-1:0] s1_g_reg;
    logic signed [17:0] sqx, sqy;
    logic [8:0]  negx, negy;
    side_t       s1_side_next;

    always_comb
    begin
        sqx  = pop_item.hx * pop_item.hx;
        sqy  = pop_item.hy * pop_item.hy;
        negx = 9'(-pop_item.hx);
        negy = 9'(-pop_item.hy);
        s1_side_next.is_query = pop_item.is_query;
        s1_side_next.ok       = pop_item.is_query && pop_item.in_image;
        s1_side_next.neg_x    = pop_item.hx[8];
        s1_side_next.neg_y    = pop_item.hy[8];
        s1_side_next.row      = pop_item.row;
        s1_side_next.col      = pop_item.col;
        s1_side_next.rgb      = pop_item.rgb;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_side_reg <= s1_side_next;
            s1_hx2_reg  <= sqx[16:0];
            s1_hy2_reg  <= sqy[16:0];
            s1_magx_reg <= pop_item.hx[8] ? negx[7:0] : pop_item.hx[7:0];
            s1_magy_reg <= pop_item.hy[8] ? negy[7:0] : pop_item.hy[7:0];
            s1_g_reg    <= GW'(focal) * GW'(focal);
        end
    end

    // stage 2: field test, denominator, numerators
    logic          s2_valid_reg;
    side_t         s2_side_reg;
    logic [GW-1:0] s2_den_reg;
    logic [NW-1:0] s2_numx_reg, s2_numy_reg;
    logic [29:0]   dsum;
    logic [47:0]   px, py;
    side_t         s2_side_next;

    always_comb
    begin
        dsum = {(12'(0) + 18'(s1_hx2_reg) + 18'(s1_hy2_reg)), 12'b0};
        px   = 48'(s1_magx_reg) * 48'(s1_g_reg);
        py   = 48'(s1_magy_reg) * 48'(s1_g_reg);
        s2_side_next    = s1_side_reg;
        s2_side_next.ok = s1_side_reg.ok && (GW'(dsum) < s1_g_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_side_reg <= s2_side_next;
            s2_den_reg  <= s1_g_reg - GW'(dsum);
            s2_numx_reg <= {px, {(FB-1){1'b0}}};
            s2_numy_reg <= {py, {(FB-1){1'b0}}};
        end
    end

    // dividers and the side line that runs beside them
    logic [QB-1:0] qx, qy;
    logic          ovfx, ovfy, rnzx, rnzy;
    logic          d_valid_reg [0:QB];
    side_t         d_side_reg  [0:QB];

    rmap_div u_div_x (
        .clk    (clk),
        .en     (adv),
        .num    (s2_numx_reg),
        .den    (s2_den_reg),
        .quot   (qx),
        .ovf    (ovfx),
        .rem_nz (rnzx)
    );

    rmap_div u_div_y (
        .clk    (clk),
        .en     (adv),
        .num    (s2_numy_reg),
        .den    (s2_den_reg),
        .quot   (qy),
        .ovf    (ovfy),
        .rem_nz (rnzy)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_side_reg[0] <= s2_side_reg;
            for (int k = 1; k <= QB; k++)
            begin
                d_side_reg[k] <= d_side_reg[k-1];
            end
        end
    end

    // map stage
    logic        m_valid_reg;
    logic        m_query_reg;
    logic        m_ok_reg;
    logic [6:0]  m_r0_reg, m_c0_reg;
    logic [7:0]  m_fr_reg, m_fc_reg;
    logic [6:0]  m_row_reg, m_col_reg;
    logic [23:0] m_rgb_reg;
    axis_t       ax, ay;
    side_t       dl;

    always_comb
    begin
        dl = d_side_reg[QB];
        ax = map_axis(qx, ovfx, rnzx, dl.neg_x, width);
        ay = map_axis(qy, ovfy, rnzy, dl.neg_y, height);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_query_reg <= dl.is_query;
            m_ok_reg    <= dl.ok && ax.ok && ay.ok;
            m_c0_reg    <= ax.idx;
            m_fc_reg    <= ax.frac;
            m_r0_reg    <= ay.idx;
            m_fr_reg    <= ay.frac;
            m_row_reg   <= dl.row;
            m_col_reg   <= dl.col;
            m_rgb_reg   <= dl.rgb;
        end
    end

    // frame store: four banks by row and column parity
    logic [6:0]    r1, c1;
    logic [AW-1:0] raddr [0:3];
    logic [1:0]    wbank;
    logic [AW-1:0] waddr;
    logic          wen;
    logic [23:0]   rd_reg [0:3];

    always_comb
    begin
        r1    = m_r0_reg + 7'd1;
        c1    = m_c0_reg + 7'd1;
        wbank = {m_row_reg[0], m_col_reg[0]};
        waddr = {m_row_reg[6:1], m_col_reg[6:1]};
        wen   = adv && m_valid_reg && !m_query_reg;
        for (int b = 0; b < 4; b++)
        begin
            raddr[b][AW-1:AW/2] = (m_r0_reg[0] == b[1]) ? m_r0_reg[6:1] : r1[6:1];
            raddr[b][AW/2-1:0]  = (m_c0_reg[0] == b[0]) ? m_c0_reg[6:1] : c1[6:1];
        end
    end

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [23:0] bank_mem [0:rmap_pkg::BANK_DEPTH-1];

        always_ff @(posedge clk)
        begin
            if (wen && (wbank == 2'(b)))
            begin
                bank_mem[waddr] <= m_rgb_reg;
            end
            if (adv)
            begin
                rd_reg[b] <= bank_mem[raddr[b]];
            end
        end
    end

    logic       a_valid_reg;
    logic       a_inside_reg;
    logic [7:0] a_fr_reg, a_fc_reg;
    logic       a_rp_reg, a_cp_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_inside_reg <= m_query_reg && m_ok_reg;
            a_fr_reg     <= m_fr_reg;
            a_fc_reg     <= m_fc_reg;
            a_rp_reg     <= m_r0_reg[0];
            a_cp_reg     <= m_c0_reg[0];
        end
    end

    // horizontal blend
    logic        i_valid_reg;
    logic        i_inside_reg;
    logic [7:0]  i_fr_reg;
    logic [15:0] i_top_reg [0:2];
    logic [15:0] i_bot_reg [0:2];
    logic [15:0] top_next  [0:2];
    logic [15:0] bot_next  [0:2];
    logic [23:0] p00, p10, p01, p11;
    logic [8:0]  wc0;
    logic [16:0] tt, tb;

    always_comb
    begin
        p00 = rd_reg[{a_rp_reg, a_cp_reg}];
        p10 = rd_reg[{a_rp_reg, !a_cp_reg}];
        p01 = rd_reg[{!a_rp_reg, a_cp_reg}];
        p11 = rd_reg[{!a_rp_reg, !a_cp_reg}];
        wc0 = 9'd256 - {1'b0, a_fc_reg};
        tt  = '0;
        tb  = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            tt = 17'(wc0) * 17'(p00[23-8*ch -: 8]) + 17'(a_fc_reg) * 17'(p10[23-8*ch -: 8]);
            tb = 17'(wc0) * 17'(p01[23-8*ch -: 8]) + 17'(a_fc_reg) * 17'(p11[23-8*ch -: 8]);
            top_next[ch] = tt[15:0];
            bot_next[ch] = tb[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_inside_reg <= a_inside_reg;
            i_fr_reg     <= a_fr_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                i_top_reg[ch] <= top_next[ch];
                i_bot_reg[ch] <= bot_next[ch];
            end
        end
    end

    // vertical blend, rounding, output register
    logic           out_valid_reg;
    rmap_pkg::rsp_t out_data_reg;
    rmap_pkg::rsp_t out_data_next;
    logic [8:0]     wr0;
    logic [24:0]    acc;
    logic [7:0]     chv [0:2];

    always_comb
    begin
        wr0 = 9'd256 - {1'b0, i_fr_reg};
        acc = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            acc = 25'(wr0) * 25'(i_top_reg[ch]) + 25'(i_fr_reg) * 25'(i_bot_reg[ch]) +
                  25'(1 << (2*FB-1));
            chv[ch] = i_inside_reg ? acc[23:16] : 8'd0;
        end
        out_data_next.out_red       = chv[0];
        out_data_next.out_green     = chv[1];
        out_data_next.out_blue      = chv[2];
        out_data_next.source_inside = i_inside_reg;
    end

    assign adv       = !out_valid_reg || rsp_ready;
    assign pop_ready = adv;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_data_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            i_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= QB; k++)
            begin
                d_valid_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            s1_valid_reg   <= pop_valid;
            s2_valid_reg   <= s1_valid_reg;
            d_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k <= QB; k++)
            begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            m_valid_reg   <= d_valid_reg[QB];
            a_valid_reg   <= m_valid_reg;
            i_valid_reg   <= a_valid_reg;
            out_valid_reg <= i_valid_reg;
        end
    end

    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && s2_side_reg.ok |-> s2_den_reg != '0)
        else $error("field test passed with zero denominator");

    a_neighbors_in_image: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg && m_query_reg && m_ok_reg |->
            ({1'b0, m_r0_reg} + 8'd1 < height) && ({1'b0, m_c0_reg} + 8'd1 < width))
        else $error("neighbor quad leaves the active image");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.source_inside |->
            out_data_reg.out_red == 8'd0 && out_data_reg.out_green == 8'd0 &&
            out_data_reg.out_blue == 8'd0)
        else $error("nonzero color on an outside or load result");

endmodule
`default_nettype wire

[rtl/core/stereographic_to_rectilinear_remap.sv]
// Stereographic to rectilinear remap with bilinear sampling.
// Request channel (req_valid/req_ready/req_data): a load transfer writes one
// RGB pixel into the 128x128 frame store; a query transfer names an output
// pixel and returns the bilinear sample at its remapped source point.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one transfer per
// request, in request order; loads answer all zero.
// Configuration over the APB port: width at 0x0, height at 0x4, focal length
// (Q8 pixels) at 0x8; write only while the block is idle.
// With no stall, a request passes one front register, one queue slot, two
// setup stages, the 19-stage radial divider, one map stage, the frame store
// read and two blend stages. Throughput is one item per cycle while the
// receiver does not stall; the four neighbors come from four frame store
// banks split by row and column parity, each read once per cycle.
// Reset clears the control state and loads the register defaults; the frame
// store holds no defined pixel until loaded.
// When the receiver stalls, the back pipeline freezes and the queue fills;
// the request side takes transfers until queue and front register are full.
`default_nettype none
module stereographic_to_rectilinear_remap #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire rmap_pkg::req_t  req_data,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rmap_pkg::rsp_t       rsp_data,
    input  wire logic            psel,
    input  wire logic            penable,
    input  wire logic            pwrite,
    input  wire logic [3:0]      paddr,
    input  wire logic [31:0]     pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic [rmap_pkg::DIM_W-1:0]   width_reg;
    logic [rmap_pkg::DIM_W-1:0]   height_reg;
    logic [rmap_pkg::FOCAL_W-1:0] focal_reg;
    logic [rmap_pkg::DIM_W-1:0]   width_eff;
    logic [rmap_pkg::DIM_W-1:0]   height_eff;
    logic [rmap_pkg::FOCAL_W-1:0] focal_eff;
    logic                         wr_en;

    logic            push_valid;
    logic            push_ready;
    rmap_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    rmap_pkg::item_t pop_item;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rmap_pkg::WIDTH_RESET;
            height_reg <= rmap_pkg::HEIGHT_RESET;
            focal_reg  <= rmap_pkg::FOCAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                rmap_pkg::REG_WIDTH:  width_reg  <= pwdata[rmap_pkg::DIM_W-1:0];
                rmap_pkg::REG_HEIGHT: height_reg <= pwdata[rmap_pkg::DIM_W-1:0];
                rmap_pkg::REG_FOCAL:  focal_reg  <= pwdata[rmap_pkg::FOCAL_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rmap_pkg::REG_WIDTH:  prdata = 32'(width_reg);
            rmap_pkg::REG_HEIGHT: prdata = 32'(height_reg);
            rmap_pkg::REG_FOCAL:  prdata = 32'(focal_reg);
            default:              prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        priority if (width_reg < rmap_pkg::DIM_MIN)
            width_eff = rmap_pkg::DIM_MIN;
        else if (width_reg > rmap_pkg::WIDTH_MAX)
            width_eff = rmap_pkg::WIDTH_MAX;
        else
            width_eff = width_reg;

        priority if (height_reg < rmap_pkg::DIM_MIN)
            height_eff = rmap_pkg::DIM_MIN;
        else if (height_reg > rmap_pkg::HEIGHT_MAX)
            height_eff = rmap_pkg::HEIGHT_MAX;
        else
            height_eff = height_reg;

        focal_eff = (focal_reg < rmap_pkg::FOCAL_MIN) ? rmap_pkg::FOCAL_MIN : focal_reg;
    end

    rmap_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .width      (width_eff),
        .height     (height_eff),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    rmap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    rmap_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .width     (width_eff),
        .height    (height_eff),
        .focal     (focal_eff),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule
`default_nettype wire
